// ===== sv/swrc_pkg.sv =====
// Shared types and constants for the sliding-window range counter.
package swrc_pkg;

    localparam int SAMPLE_W = 30;
    localparam int WIDTH_W  = 7;
    localparam int COUNT_W  = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT  = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET = 7'd2;
    localparam logic [SAMPLE_W-1:0] LIMIT_RESET = '0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                start_req;
    } in_t;

    typedef struct packed {
        logic                window_full;
        logic [SAMPLE_W-1:0] window_max;
        logic [SAMPLE_W-1:0] window_min;
        logic                in_range;
        logic [COUNT_W-1:0]  match_count;
    } out_t;

    // Per-sample request to one deque unit
    typedef struct packed {
        logic                clear;
        logic [SAMPLE_W-1:0] sample;
        logic [WIDTH_W-1:0]  width;
    } dq_req_t;

    typedef struct packed {
        logic                busy;
        logic [SAMPLE_W-1:0] head_value;
    } dq_stat_t;

endpackage

// ===== sv/sliding_window_range_counter_core.sv =====
// Sliding-window max/min tracker that flags and counts narrow-range windows.
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+---------------------
//  in       | in_valid, in_stall, in_data      | sink      | swrc_pkg::in_t
//  out      | out_valid, out_stall, out_data   | source    | swrc_pkg::out_t
//  cfg      | cfg_valid, cfg_ready, cfg_index  | sink      | cfg_data (30 bits)
//
// A result loads once the slower of the two deque sequencers running side by side
// has finished its tail pops, head expiries and push, and the output register is
// free; a deque that runs empty goes straight to its push. The next sample is
// taken the cycle after the result loads.
// in_stall is high from the accepting edge until the result is loaded.
// The result waits in an output register, so a new sample is taken while out
// is stalled. Reset leaves both deques empty, width 2, limit 0, count 0.
// cfg_ready is always high; write only while idle.
module sliding_window_range_counter_core #(
    parameter int WINDOW_MAX = 64,
    parameter int POS_BITS   = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  swrc_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output swrc_pkg::out_t                    out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrc_pkg::SAMPLE_W-1:0]     cfg_data
);

    localparam int CW = $clog2(WINDOW_MAX + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;

    logic [swrc_pkg::WIDTH_W-1:0]  width_reg;
    logic [swrc_pkg::SAMPLE_W-1:0] limit_reg;
    logic [POS_BITS-1:0]           pos_reg;
    logic [CW-1:0]                 fill_reg, fill_next;
    logic [swrc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          out_valid_reg;
    swrc_pkg::out_t                out_reg, result;

    logic [swrc_pkg::WIDTH_W-1:0]  width_nz;
    logic [swrc_pkg::WIDTH_W-1:0]  weff;
    logic [POS_BITS-1:0]           pos_cur;
    logic [CW-1:0]                 fill_base;
    logic                          in_fire;
    logic                          out_fire;
    logic                          finish;
    logic                          full;
    logic                          ok;
    logic [swrc_pkg::SAMPLE_W-1:0] hi, lo;

    swrc_pkg::dq_req_t  req;
    swrc_pkg::dq_stat_t max_st, min_st;

    assign width_nz = (width_reg == '0) ? swrc_pkg::WIDTH_W'(1) : width_reg;
    assign weff = (32'(width_nz) > 32'(WINDOW_MAX)) ? swrc_pkg::WIDTH_W'(WINDOW_MAX)
                                                   : width_nz;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    assign pos_cur   = in_data.start_req ? '0 : pos_reg;
    assign fill_base = in_data.start_req ? '0 : fill_reg;
    assign fill_next = (fill_base == CW'(WINDOW_MAX)) ? fill_base : fill_base + CW'(1);

    assign req.clear  = in_data.start_req;
    assign req.sample = in_data.sample;
    assign req.width  = weff;

    swrc_deque #(
        .WINDOW_MAX(WINDOW_MAX),
        .POS_BITS  (POS_BITS),
        .IS_MAX    (1'b1)
    ) u_max_dq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (in_fire),
        .req   (req),
        .pos   (pos_cur),
        .status(max_st)
    );

    swrc_deque #(
        .WINDOW_MAX(WINDOW_MAX),
        .POS_BITS  (POS_BITS),
        .IS_MAX    (1'b0)
    ) u_min_dq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (in_fire),
        .req   (req),
        .pos   (pos_cur),
        .status(min_st)
    );

    assign finish = (state_reg == ST_RUN) && !max_st.busy && !min_st.busy
                    && (!out_valid_reg || !out_stall);

    assign full = 32'(fill_reg) >= 32'(weff);
    assign hi   = full ? max_st.head_value : '0;
    assign lo   = full ? min_st.head_value : '0;
    assign ok   = full && (hi >= lo) && ((hi - lo) <= limit_reg);
    assign count_next = (ok && count_reg != swrc_pkg::COUNT_MAX) ?
                        count_reg + swrc_pkg::COUNT_W'(1) : count_reg;

    always_comb
    begin
        result.window_full = full;
        result.window_max  = hi;
        result.window_min  = lo;
        result.in_range    = ok;
        result.match_count = count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= swrc_pkg::WIDTH_RESET;
            limit_reg     <= swrc_pkg::LIMIT_RESET;
            pos_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    swrc_pkg::REG_WINDOW_WIDTH: width_reg <= cfg_data[swrc_pkg::WIDTH_W-1:0];
                    swrc_pkg::REG_RANGE_LIMIT:  limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                pos_reg  <= pos_cur + POS_BITS'(1);
                fill_reg <= fill_next;
                if (in_data.start_req)
                begin
                    count_reg <= '0;
                end
            end
            if (finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A flagged window is always a full one
    a_range_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.in_range || out_data.window_full))
        else $error("in_range set on a partial window");

    // Deque heads must agree: max never below min on a full window
    a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.window_full) |-> (out_data.window_max >= out_data.window_min))
        else $error("window max below window min");

    // Deque sequencers only run while a sample is in flight
    a_dq_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!max_st.busy && !min_st.busy))
        else $error("deque busy while core idle");

    // Fill count saturates at the deque depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(WINDOW_MAX))
        else $error("fill count beyond window depth");

endmodule

// ===== sv/swrc_deque.sv =====
// Monotonic deque with one compare unit stepped by a small sequencer.
module swrc_deque #(
    parameter int WINDOW_MAX = 64,
    parameter int POS_BITS   = 20,
    parameter bit IS_MAX     = 1'b1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  swrc_pkg::dq_req_t     req,
    input  logic [POS_BITS-1:0]   pos,
    output swrc_pkg::dq_stat_t    status
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = swrc_pkg::SAMPLE_W + POS_BITS;
    localparam logic [AW:0] DEPTH = (AW + 1)'(WINDOW_MAX);

    localparam logic [1:0] DQ_IDLE = 2'd0;
    localparam logic [1:0] DQ_TAIL = 2'd1;
    localparam logic [1:0] DQ_HEAD = 2'd2;
    localparam logic [1:0] DQ_PUSH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [swrc_pkg::SAMPLE_W-1:0] v_reg;
    logic [POS_BITS-1:0]           p_reg;
    logic [swrc_pkg::WIDTH_W-1:0]  w_reg;
    logic [swrc_pkg::SAMPLE_W-1:0] head_val_reg, head_val_next;

    logic [EW-1:0] mem [WINDOW_MAX];
    logic [EW-1:0] rd_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          wr_en;

    logic [swrc_pkg::SAMPLE_W-1:0] rval;
    logic [POS_BITS-1:0]           rpos;
    logic [AW-1:0]                 head_e;
    logic [CW-1:0]                 cnt_e;
    logic [AW-1:0]                 head_step;
    logic                          dominated;
    logic                          expired;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= DEPTH)
        begin
            sum = sum - DEPTH;
        end
        return sum[AW-1:0];
    endfunction

    assign rval = rd_reg[EW-1:POS_BITS];
    assign rpos = rd_reg[POS_BITS-1:0];

    assign head_e = req.clear ? '0 : head_reg;
    assign cnt_e  = req.clear ? '0 : cnt_reg;
    assign head_step = (head_reg == AW'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;

    // Ties pop too
    assign dominated = IS_MAX ? (v_reg >= rval) : (v_reg <= rval);
    // Age wraps modulo 2^POS_BITS
    assign expired = (p_reg - rpos) >= POS_BITS'(w_reg);
    assign waddr   = slot(head_reg, (AW + 1)'(cnt_reg));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        head_val_next = head_val_reg;
        raddr         = head_reg;
        wr_en         = 1'b0;
        unique case (state_reg)
            DQ_IDLE:
            begin
                if (go)
                begin
                    head_next = head_e;
                    cnt_next  = cnt_e;
                    if (cnt_e == '0)
                    begin
                        state_next = DQ_PUSH;
                    end
                    else
                    begin
                        raddr      = slot(head_e, (AW + 1)'(cnt_e - CW'(1)));
                        state_next = DQ_TAIL;
                    end
                end
            end
            DQ_TAIL:
            begin
                if (dominated)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = DQ_PUSH;
                    end
                    else
                    begin
                        // fetch the next tail while this pop retires
                        raddr = slot(head_reg, (AW + 1)'(cnt_reg - CW'(2)));
                    end
                end
                else
                begin
                    raddr      = head_reg;
                    state_next = DQ_HEAD;
                end
            end
            DQ_HEAD:
            begin
                if (expired)
                begin
                    head_next = head_step;
                    cnt_next  = cnt_reg - CW'(1);
                    raddr     = head_step;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = DQ_PUSH;
                    end
                end
                else
                begin
                    head_val_next = rval;
                    state_next    = DQ_PUSH;
                end
            end
            DQ_PUSH:
            begin
                // a legal width never fills the deque before this push
                wr_en    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == '0)
                begin
                    head_val_next = v_reg;
                end
                state_next = DQ_IDLE;
            end
            default:
            begin
                state_next = DQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DQ_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_val_reg <= head_val_next;
        if (state_reg == DQ_IDLE && go)
        begin
            v_reg <= req.sample;
            p_reg <= pos;
            w_reg <= req.width;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= {v_reg, p_reg};
        end
        rd_reg <= mem[raddr];
    end

    assign status.busy       = (state_reg != DQ_IDLE);
    assign status.head_value = head_val_reg;

endmodule
